// ===== rtl/bvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bvt_pkg
// Types and constants shared by the byte vocabulary tokenizer modules.
// ----------------------------------------------------------------------------
package bvt_pkg;

  localparam int unsigned VocabDepth = 256;
  localparam int unsigned IdW        = 8;
  localparam int unsigned CountW     = 9;
  localparam int unsigned WrittenW   = 16;

  localparam logic [WrittenW-1:0] LimitReset = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LEARN  = 2'd1,
    CMD_ENCODE = 2'd2,
    CMD_DECODE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         byte_in;
    logic signed [31:0] token_in;
    logic               first_of_call;
  } req_t;

  typedef struct packed {
    logic                produced;
    logic [7:0]          value_out;
    logic [WrittenW-1:0] written_count;
    logic [CountW-1:0]   vocab_size;
  } rsp_t;

  typedef struct packed {
    logic           clear;
    logic           learn;
    logic [7:0]     byte_val;
    logic [IdW-1:0] id;
  } wr_t;

endpackage
`default_nettype wire

// ===== rtl/bvt_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bvt_store
// Vocabulary storage: byte-to-id and id-to-byte memories with registered
// reads, known flags per byte and the vocabulary count.
// ----------------------------------------------------------------------------
module bvt_store (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [7:0]                 rd_byte,
  input  wire logic [bvt_pkg::IdW-1:0]    rd_id,
  input  wire bvt_pkg::wr_t               wr,
  output logic [bvt_pkg::IdW-1:0]         id_data,
  output logic [7:0]                      byte_data,
  output logic                            known_hit,
  output logic [bvt_pkg::CountW-1:0]      vocab_count
);

  logic [bvt_pkg::IdW-1:0] byte_ids [bvt_pkg::VocabDepth];
  logic [7:0]              id_bytes [bvt_pkg::VocabDepth];
  logic [bvt_pkg::VocabDepth-1:0] known;
  logic [7:0]              byte_q;

  always_ff @(posedge clk) begin
    if (wr.learn) begin
      byte_ids[wr.byte_val] <= wr.id;
      id_bytes[wr.id]       <= wr.byte_val;
    end
    if (rd_en) begin
      id_data   <= byte_ids[rd_byte];
      byte_data <= id_bytes[rd_id];
      byte_q    <= rd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      known       <= '0;
      vocab_count <= '0;
    end else if (wr.learn) begin
      known[wr.byte_val] <= 1'b1;
      vocab_count        <= vocab_count + bvt_pkg::CountW'(1);
    end
  end

  assign known_hit = known[byte_q];

endmodule
`default_nettype wire

// ===== rtl/byte_vocabulary_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_vocabulary_tokenizer
// Byte vocabulary with learn, encode, decode and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one command beat:
//   clear, learn a byte, encode a byte or decode an id. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one beat per command with
//   the produced flag, the value, the written count of the current call
//   and the vocabulary size.
//   cfg_we / cfg_data write the output limit; write only while idle.
// Timing:
//   An accepted beat reads both vocabulary memories at the accept edge;
//   once the response register is free, the command is resolved, written
//   back and loaded into the response register. req_stall follows busy,
//   so a new beat is taken only after the current one has committed.
// Reset:
//   rst clears the vocabulary, the written count and rsp_valid, and sets
//   the limit to 65535. No clearing pass is needed.
// Stall:
//   While rsp_stall holds a response, the next beat is still accepted and
//   waits in execution until the response register frees.
// ----------------------------------------------------------------------------
module byte_vocabulary_tokenizer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire bvt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bvt_pkg::rsp_t      rsp,
  input  wire logic          cfg_we,
  input  wire logic [bvt_pkg::WrittenW-1:0] cfg_data
);

  logic                             busy;
  bvt_pkg::req_t                    item;
  logic [bvt_pkg::WrittenW-1:0]     emitted;
  logic [bvt_pkg::WrittenW-1:0]     limit;

  logic                             accept;
  logic                             commit;
  bvt_pkg::wr_t                     wr;
  logic [bvt_pkg::IdW-1:0]          id_data;
  logic [7:0]                       byte_data;
  logic                             known_hit;
  logic [bvt_pkg::CountW-1:0]       vocab_count;

  logic [bvt_pkg::WrittenW-1:0]     emit_base;
  logic [bvt_pkg::WrittenW-1:0]     emitted_next;
  logic [bvt_pkg::CountW-1:0]       vocab_next;
  logic                             produced;
  logic [7:0]                       value;
  logic                             id_ok;

  assign req_stall = busy;
  assign accept    = req_valid && !busy;
  assign commit    = busy && (!rsp_valid || !rsp_stall);

  bvt_store u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (accept),
    .rd_byte     (req.byte_in),
    .rd_id       (req.token_in[bvt_pkg::IdW-1:0]),
    .wr          (wr),
    .id_data     (id_data),
    .byte_data   (byte_data),
    .known_hit   (known_hit),
    .vocab_count (vocab_count)
  );

  assign id_ok = !item.token_in[31] && (item.token_in[30:bvt_pkg::CountW] == '0)
                 && (item.token_in[bvt_pkg::CountW-1:0] < vocab_count);

  always_comb begin
    emit_base    = item.first_of_call ? '0 : emitted;
    emitted_next = emit_base;
    vocab_next   = vocab_count;
    produced     = 1'b0;
    value        = '0;
    wr.clear     = 1'b0;
    wr.learn     = 1'b0;
    wr.byte_val  = item.byte_in;
    wr.id        = vocab_count[bvt_pkg::IdW-1:0];
    case (bvt_pkg::cmd_t'(item.command))
      bvt_pkg::CMD_CLEAR: begin
        wr.clear   = commit;
        vocab_next = '0;
      end
      bvt_pkg::CMD_LEARN: begin
        produced = 1'b1;
        if (known_hit) begin
          value = id_data;
        end else begin
          wr.learn   = commit;
          value      = vocab_count[bvt_pkg::IdW-1:0];
          vocab_next = vocab_count + bvt_pkg::CountW'(1);
        end
      end
      bvt_pkg::CMD_ENCODE: begin
        if (emit_base < limit && known_hit) begin
          produced = 1'b1;
          value    = id_data;
        end
      end
      bvt_pkg::CMD_DECODE: begin
        if (emit_base < limit && id_ok) begin
          produced = 1'b1;
          value    = byte_data;
        end
      end
      default: begin
        produced = 1'b0;
      end
    endcase
    if (produced && item.command != bvt_pkg::CMD_LEARN) begin
      emitted_next = emit_base + bvt_pkg::WrittenW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      emitted   <= '0;
      limit     <= bvt_pkg::LimitReset;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
      end
      if (commit) begin
        emitted   <= emitted_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (commit) begin
      rsp.produced      <= produced;
      rsp.value_out     <= value;
      rsp.written_count <= emitted_next;
      rsp.vocab_size    <= vocab_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat did not enter execution");

  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp_valid)
    else $error("committed beat gave no response");

  a_idle_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.produced |-> rsp.value_out == '0)
    else $error("value present without a produced item");

  a_vocab_bound: assert property (@(posedge clk) disable iff (rst)
    vocab_count <= bvt_pkg::CountW'(bvt_pkg::VocabDepth))
    else $error("vocabulary count beyond depth");
`endif

endmodule
`default_nettype wire

// ===== dv/byte_vocabulary_tokenizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_vocabulary_tokenizer_test
// Self-checking bench for the byte vocabulary tokenizer. A directed table
// covers empty-vocabulary lookups, id extremes, clear, repeat learns and
// output limits of 0 and 1. Random phases follow, each under its own limit,
// plus a phase that fills all 256 entries. Every response beat is checked
// field by field against table values or an in-bench vocabulary model.
// ----------------------------------------------------------------------------
module byte_vocabulary_tokenizer_test;

  localparam int CycleLimit  = 300000;
  localparam int PhaseBeats  = 155;
  localparam int DrainCycles = 4;

  typedef struct {
    bit            is_limit;
    logic [15:0]   limit;
    bvt_pkg::req_t beat;
    bit            typed;
    bvt_pkg::rsp_t want;
  } script_row_t;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  bvt_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  bvt_pkg::rsp_t rsp;
  logic          cfg_we;
  logic [15:0]   cfg_data;

  // vocabulary model
  bit          known_byte [256];
  logic [7:0]  id_of_byte [256];
  logic [7:0]  byte_of_id [256];
  int          vocab_n;
  int          written_n;
  logic [15:0] limit_q;

  bvt_pkg::rsp_t pending_rsps[$];
  script_row_t   script[$];
  int            mismatches;
  int            cycles;
  bit            steady;

  byte_vocabulary_tokenizer u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) @(posedge clk) cycles++;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bvt_pkg::rsp_t tokenize_beat(bvt_pkg::req_t b);
    bvt_pkg::rsp_t r;
    int            tok;
    r   = '0;
    tok = b.token_in;
    if (b.first_of_call) written_n = 0;
    case (bvt_pkg::cmd_t'(b.command))
      bvt_pkg::CMD_CLEAR: begin
        foreach (known_byte[i]) known_byte[i] = 1'b0;
        vocab_n = 0;
      end
      bvt_pkg::CMD_LEARN: begin
        if (!known_byte[b.byte_in]) begin
          known_byte[b.byte_in]  = 1'b1;
          id_of_byte[b.byte_in]  = 8'(vocab_n);
          byte_of_id[8'(vocab_n)] = b.byte_in;
          vocab_n++;
        end
        r.produced  = 1'b1;
        r.value_out = id_of_byte[b.byte_in];
      end
      default: begin
        if (written_n < int'(limit_q)) begin
          if (b.command == bvt_pkg::CMD_ENCODE) begin
            if (known_byte[b.byte_in]) begin
              r.produced  = 1'b1;
              r.value_out = id_of_byte[b.byte_in];
            end
          end else if (tok >= 0 && tok < vocab_n) begin
            r.produced  = 1'b1;
            r.value_out = byte_of_id[tok[7:0]];
          end
          if (r.produced) written_n++;
        end
      end
    endcase
    r.written_count = 16'(written_n);
    r.vocab_size    = 9'(vocab_n);
    return r;
  endfunction

  function automatic void beat_row(bvt_pkg::cmd_t c, logic [7:0] by, int tok, bit first,
                                   bit typed, bit p = 0, logic [7:0] v = 0, int wc = 0,
                                   int vs = 0);
    script_row_t row;
    row                    = '{default: '0};
    row.beat.command       = c;
    row.beat.byte_in       = by;
    row.beat.token_in      = tok;
    row.beat.first_of_call = first;
    row.typed              = typed;
    row.want.produced      = p;
    row.want.value_out     = v;
    row.want.written_count = 16'(wc);
    row.want.vocab_size    = 9'(vs);
    script.push_back(row);
  endfunction

  function automatic void limit_row(logic [15:0] v);
    script_row_t row;
    row          = '{default: '0};
    row.is_limit = 1'b1;
    row.limit    = v;
    script.push_back(row);
  endfunction

  function automatic bvt_pkg::req_t rand_beat();
    bvt_pkg::req_t r;
    int            sel;
    r.byte_in       = 8'($urandom);
    r.token_in      = $urandom;
    r.first_of_call = ($urandom_range(7) == 0);
    sel             = $urandom_range(99);
    if (sel < 2) r.command = bvt_pkg::CMD_CLEAR;
    else if (sel < 30) r.command = bvt_pkg::CMD_LEARN;
    else if (sel < 65) r.command = bvt_pkg::CMD_ENCODE;
    else r.command = bvt_pkg::CMD_DECODE;
    sel = $urandom_range(99);
    if (r.command == bvt_pkg::CMD_ENCODE && vocab_n > 0 && sel < 70) begin
      r.byte_in = byte_of_id[8'($urandom_range(vocab_n - 1))];
    end else if (r.command == bvt_pkg::CMD_DECODE) begin
      if (sel < 55 && vocab_n > 0) r.token_in = $urandom_range(vocab_n - 1);
      else if (sel < 70) r.token_in = vocab_n + $urandom_range(3);
      else if (sel < 85) r.token_in = $urandom | 32'h8000_0000;
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    mismatches++;
    $display("mismatch at cycle %0d: %0s got %0h want %0h", cycles, what, got, want);
  endtask

  task automatic send_beat(bvt_pkg::req_t r, bit typed, bvt_pkg::rsp_t want);
    bvt_pkg::rsp_t predicted;
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    predicted = tokenize_beat(r);
    pending_rsps.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limit_q  = v;
  endtask

  // response side: check each beat, stall at random
  initial begin
    bvt_pkg::rsp_t want;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_rsps.size() == 0) begin
          report("unexpected beat", 32'(rsp), 0);
        end else begin
          want = pending_rsps.pop_front();
          if (rsp.produced != want.produced)
            report("produced", int'(rsp.produced), int'(want.produced));
          if (rsp.value_out != want.value_out)
            report("value_out", int'(rsp.value_out), int'(want.value_out));
          if (rsp.written_count != want.written_count)
            report("written_count", int'(rsp.written_count), int'(want.written_count));
          if (rsp.vocab_size != want.vocab_size)
            report("vocab_size", int'(rsp.vocab_size), int'(want.vocab_size));
        end
      end
      rsp_stall <= !steady && ($urandom_range(99) < 31);
    end
  end

  initial begin
    logic [15:0]   phase_limits [8];
    logic [7:0]    order [256];
    logic [7:0]    swap;
    int            j;
    bvt_pkg::req_t r;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    steady    = 1'b0;
    foreach (known_byte[i]) known_byte[i] = 1'b0;
    vocab_n   = 0;
    written_n = 0;
    limit_q   = bvt_pkg::LimitReset;

    beat_row(bvt_pkg::CMD_ENCODE, 8'h41, 0, 1, 1, 0, 8'h00, 0, 0);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 0, 0, 1, 0, 8'h00, 0, 0);
    beat_row(bvt_pkg::CMD_DECODE, 8'hFF, -1, 0, 1, 0, 8'h00, 0, 0);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 32'h8000_0000, 0, 1, 0, 8'h00, 0, 0);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 32'h7FFF_FFFF, 0, 1, 0, 8'h00, 0, 0);
    beat_row(bvt_pkg::CMD_LEARN,  8'h00, 0, 0, 1, 1, 8'h00, 0, 1);
    beat_row(bvt_pkg::CMD_LEARN,  8'hFF, 0, 0, 1, 1, 8'h01, 0, 2);
    beat_row(bvt_pkg::CMD_LEARN,  8'h00, 0, 0, 1, 1, 8'h00, 0, 2);
    beat_row(bvt_pkg::CMD_LEARN,  8'hA5, 0, 0, 1, 1, 8'h02, 0, 3);
    beat_row(bvt_pkg::CMD_ENCODE, 8'hFF, 0, 0, 1, 1, 8'h01, 1, 3);
    beat_row(bvt_pkg::CMD_ENCODE, 8'h5A, 0, 0, 1, 0, 8'h00, 1, 3);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 2, 0, 1, 1, 8'hA5, 2, 3);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 3, 0, 1, 0, 8'h00, 2, 3);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 0, 0, 1, 1, 8'h00, 3, 3);
    beat_row(bvt_pkg::CMD_ENCODE, 8'h00, 0, 1, 1, 1, 8'h00, 1, 3);
    beat_row(bvt_pkg::CMD_CLEAR,  8'h00, 0, 0, 1, 0, 8'h00, 1, 0);
    beat_row(bvt_pkg::CMD_ENCODE, 8'hFF, 0, 0, 1, 0, 8'h00, 1, 0);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 0, 0, 1, 0, 8'h00, 1, 0);
    beat_row(bvt_pkg::CMD_LEARN,  8'h5A, 0, 1, 1, 1, 8'h00, 0, 1);
    beat_row(bvt_pkg::CMD_CLEAR,  8'h00, 0, 1, 1, 0, 8'h00, 0, 0);
    beat_row(bvt_pkg::CMD_LEARN,  8'h80, 0, 0, 1, 1, 8'h00, 0, 1);
    limit_row(16'd0);
    beat_row(bvt_pkg::CMD_ENCODE, 8'h80, 0, 1, 1, 0, 8'h00, 0, 1);
    beat_row(bvt_pkg::CMD_LEARN,  8'h81, 0, 0, 1, 1, 8'h01, 0, 2);
    limit_row(16'd1);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 1, 0, 0);
    beat_row(bvt_pkg::CMD_ENCODE, 8'h80, 0, 0, 1, 0, 8'h00, 1, 2);
    beat_row(bvt_pkg::CMD_DECODE, 8'h00, 0, 1, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_limit) set_limit(script[i].limit);
      else send_beat(script[i].beat, script[i].typed, script[i].want);
    end

    phase_limits = '{16'hFFFF, 16'd0, 16'd1, 16'd4, 16'd0, 16'd30, 16'hFFFE, 16'd2};
    phase_limits[4] = 16'($urandom);
    foreach (phase_limits[p]) begin
      set_limit(phase_limits[p]);
      steady = (p == 4);
      for (int n = 0; n < PhaseBeats; n++) begin
        if ($urandom_range(99) == 0) wait_idle();
        send_beat(rand_beat(), 1'b0, '0);
      end
    end
    steady = 1'b0;

    // fill every vocabulary slot, then decode random ids and ids past the top
    set_limit(16'hFFFF);
    foreach (order[i]) order[i] = 8'(i);
    for (int i = 0; i < 255; i++) begin
      j        = $urandom_range(255, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    r               = '0;
    r.command       = bvt_pkg::CMD_CLEAR;
    r.first_of_call = 1'b1;
    send_beat(r, 1'b0, '0);
    foreach (order[i]) begin
      r               = rand_beat();
      r.command       = bvt_pkg::CMD_LEARN;
      r.byte_in       = order[i];
      send_beat(r, 1'b0, '0);
    end
    for (int n = 0; n < 40; n++) begin
      r          = rand_beat();
      r.command  = bvt_pkg::CMD_DECODE;
      r.token_in = (n % 4 == 0) ? 256 + $urandom_range(1) : $urandom_range(255);
      send_beat(r, 1'b0, '0);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bvt_pkg.sv
rtl/bvt_store.sv
rtl/byte_vocabulary_tokenizer.sv
dv/byte_vocabulary_tokenizer_test.sv
